// ----- rtl/ste_pkg.sv -----
// shared types, constants and register codes for the silence trim detector
// no dependencies
package ste_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int SAMPLE_W     = 24;
  localparam int MAG_W        = 24;
  localparam int CNT_W        = 16;
  localparam int POS_W        = 48;
  localparam int CHAN_W       = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 24;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 2'd3;

  localparam logic FUNC_FRAME  = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  typedef struct packed {
    logic [MAG_W-1:0] threshold;
    logic [CNT_W-1:0] win_len;
    logic [CNT_W-1:0] hyst_len;
  } ste_cfg_t;

  typedef struct packed {
    logic             func;
    logic [MAG_W-1:0] peak;
    logic [POS_W-1:0] total;
  } ste_frame_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] last;
    logic [POS_W-1:0] total;
  } ste_res_t;

endpackage

// ----- rtl/ste_ifs.sv -----
// valid/ready channel interfaces for input items, result items and register writes
// depends on ste_pkg
interface ste_in_if import ste_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic signed [SAMPLE_W-1:0] sample_0;
  logic signed [SAMPLE_W-1:0] sample_1;
  logic signed [SAMPLE_W-1:0] sample_2;
  logic signed [SAMPLE_W-1:0] sample_3;
  logic        [POS_W-1:0]    track_len;

  modport source (output valid, func, sample_0, sample_1, sample_2, sample_3, track_len,
                  input ready);
  modport sink   (input valid, func, sample_0, sample_1, sample_2, sample_3, track_len,
                  output ready);
endinterface

interface ste_out_if import ste_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             sound_found;
  logic [POS_W-1:0] begin_frame;
  logic [POS_W-1:0] end_frame;

  modport source (output valid, sound_found, begin_frame, end_frame, input ready);
  modport sink   (input valid, sound_found, begin_frame, end_frame, output ready);
endinterface

interface ste_cfg_if import ste_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/ste_lane.sv -----
// one sample lane: magnitude of a signed 24-bit sample, zero when the lane is unused
// depends on ste_pkg
module ste_lane import ste_pkg::*; (
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       en,
  output logic        [MAG_W-1:0]    mag
);

  logic [MAG_W-1:0] raw;

  assign raw = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;
  assign mag = en ? raw : '0;

endmodule

// ----- rtl/ste_merge.sv -----
// merge stage: largest lane magnitude of a frame, registered with the item
// depends on ste_pkg
module ste_merge import ste_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [MAG_W-1:0]       lane_mag [MAX_CHANNELS],
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_func,
  input  logic [POS_W-1:0]       in_total,
  output logic                   frm_valid,
  input  logic                   frm_ready,
  output ste_frame_t             frm
);

  logic             valid_r;
  ste_frame_t       frm_r;
  ste_frame_t       frm_nxt;
  logic [MAG_W-1:0] peak;

  always_comb begin
    peak = '0;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      if (lane_mag[c] > peak) begin
        peak = lane_mag[c];
      end
    end
  end

  assign frm_nxt.func  = in_func;
  assign frm_nxt.peak  = peak;
  assign frm_nxt.total = in_total;

  assign in_ready  = !valid_r || frm_ready;
  assign frm_valid = valid_r;
  assign frm       = frm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      frm_r <= frm_nxt;
    end
  end

endmodule

// ----- rtl/ste_tracker.sv -----
// window and hysteresis tracker: closes windows, follows sound runs, holds finish results
// depends on ste_pkg
module ste_tracker import ste_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ste_cfg_t   cfg,
  input  logic       frm_valid,
  output logic       frm_ready,
  input  ste_frame_t frm,
  output logic       res_valid,
  input  logic       res_ready,
  output ste_res_t   res
);

  logic [MAG_W-1:0] window_peak_r,    window_peak_nxt;
  logic [CNT_W-1:0] frames_in_win_r,  frames_in_win_nxt;
  logic [POS_W-1:0] window_begin_r,   window_begin_nxt;
  logic [CNT_W-1:0] loud_count_r,     loud_count_nxt;
  logic [CNT_W-1:0] quiet_count_r,    quiet_count_nxt;
  logic [POS_W-1:0] run_begin_r,      run_begin_nxt;
  logic             sounding_r,       sounding_nxt;
  logic             found_r,          found_nxt;
  logic [POS_W-1:0] first_pos_r,      first_pos_nxt;
  logic [POS_W-1:0] last_pos_r,       last_pos_nxt;
  logic [POS_W-1:0] frame_pos_r,      frame_pos_nxt;
  logic             res_valid_r;
  ste_res_t         res_r;

  logic             take;
  logic             is_finish;
  logic [CNT_W-1:0] wlen;
  logic [CNT_W-1:0] need;
  logic [MAG_W-1:0] peak_new;
  logic [CNT_W-1:0] fiw_inc;
  logic [POS_W-1:0] pos_inc;
  logic             do_close;
  logic [MAG_W-1:0] close_peak;
  logic [POS_W-1:0] close_end;

  assign is_finish = (frm.func == FUNC_FINISH);
  assign frm_ready = !is_finish || !res_valid_r || res_ready;
  assign take      = frm_valid && frm_ready;

  assign wlen     = (cfg.win_len == '0) ? CNT_W'(1) : cfg.win_len;
  assign need     = (cfg.hyst_len == '0) ? CNT_W'(1) : cfg.hyst_len;
  assign peak_new = (frm.peak > window_peak_r) ? frm.peak : window_peak_r;
  assign fiw_inc  = (frames_in_win_r == CNT_MAX) ? CNT_MAX : frames_in_win_r + CNT_W'(1);
  assign pos_inc  = (frame_pos_r == POS_MAX) ? POS_MAX : frame_pos_r + POS_W'(1);

  always_comb begin
    if (is_finish) begin
      do_close   = (frames_in_win_r != '0);
      close_peak = window_peak_r;
      close_end  = frame_pos_r;
    end else begin
      do_close   = (fiw_inc >= wlen);
      close_peak = peak_new;
      close_end  = pos_inc;
    end
  end

  always_comb begin
    window_peak_nxt   = window_peak_r;
    frames_in_win_nxt = frames_in_win_r;
    window_begin_nxt  = window_begin_r;
    loud_count_nxt    = loud_count_r;
    quiet_count_nxt   = quiet_count_r;
    run_begin_nxt     = run_begin_r;
    sounding_nxt      = sounding_r;
    found_nxt         = found_r;
    first_pos_nxt     = first_pos_r;
    last_pos_nxt      = last_pos_r;
    frame_pos_nxt     = frame_pos_r;
    if (!is_finish) begin
      window_peak_nxt   = peak_new;
      frames_in_win_nxt = fiw_inc;
      frame_pos_nxt     = pos_inc;
    end
    if (do_close) begin
      if (close_peak > cfg.threshold) begin
        if (loud_count_r == '0) begin
          run_begin_nxt = window_begin_r;
        end
        loud_count_nxt  = (loud_count_r == CNT_MAX) ? CNT_MAX : loud_count_r + CNT_W'(1);
        quiet_count_nxt = '0;
        if (!sounding_r && (loud_count_nxt >= need)) begin
          sounding_nxt = 1'b1;
          if (!found_r) begin
            found_nxt     = 1'b1;
            first_pos_nxt = run_begin_nxt;
          end
        end
        if (sounding_nxt) begin
          last_pos_nxt = close_end;
        end
      end else begin
        loud_count_nxt  = '0;
        quiet_count_nxt = (quiet_count_r == CNT_MAX) ? CNT_MAX : quiet_count_r + CNT_W'(1);
        if (sounding_r && (quiet_count_nxt >= need)) begin
          sounding_nxt = 1'b0;
        end
      end
      window_peak_nxt   = '0;
      frames_in_win_nxt = '0;
      window_begin_nxt  = close_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_peak_r   <= '0;
      frames_in_win_r <= '0;
      window_begin_r  <= '0;
      loud_count_r    <= '0;
      quiet_count_r   <= '0;
      run_begin_r     <= '0;
      sounding_r      <= 1'b0;
      found_r         <= 1'b0;
      first_pos_r     <= '0;
      last_pos_r      <= '0;
      frame_pos_r     <= '0;
    end else if (take) begin
      window_peak_r   <= window_peak_nxt;
      frames_in_win_r <= frames_in_win_nxt;
      window_begin_r  <= window_begin_nxt;
      loud_count_r    <= loud_count_nxt;
      quiet_count_r   <= quiet_count_nxt;
      run_begin_r     <= run_begin_nxt;
      sounding_r      <= sounding_nxt;
      found_r         <= found_nxt;
      first_pos_r     <= first_pos_nxt;
      last_pos_r      <= last_pos_nxt;
      frame_pos_r     <= frame_pos_nxt;
    end
  end

  // finish snapshot waiting for the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (take && is_finish) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_finish) begin
      res_r.found <= found_nxt;
      res_r.first <= first_pos_nxt;
      res_r.last  <= last_pos_nxt;
      res_r.total <= frm.total;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  a_sound_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
    sounding_r |-> found_r)
    else $error("sounding without a recorded sound start");

  a_runs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !((loud_count_r != '0) && (quiet_count_r != '0)))
    else $error("loud and quiet runs counted at once");

  a_finish_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (take && is_finish) |=> (frames_in_win_r == '0))
    else $error("partial window left open after finish");

  a_end_after_begin: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (last_pos_r >= first_pos_r))
    else $error("last sound end before first sound start");

endmodule

// ----- rtl/silence_trim_detector.sv -----
// Silence trim detector. Each input item is either an audio frame of up to four signed
// 24-bit samples (func = 0) or a finish request (func = 1). Frames produce no result; a
// finish closes any partial window and returns one item with sound_found, begin_frame and
// end_frame. One item is taken per clock: the lane magnitudes and their maximum are
// registered in a first stage, window and hysteresis state updates in the second, and the
// result passes through a snapshot register and the output register. Frames keep flowing
// while a result waits; input stalls only when a finish finds both result registers full.
// Register writes are taken every cycle and must only be made while the block is idle.
// depends on ste_pkg, ste_ifs, ste_lane, ste_merge, ste_tracker
module silence_trim_detector import ste_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  ste_in_if.sink   in_ch,
  ste_out_if.source out_ch,
  ste_cfg_if.sink  cfg_ch
);

  logic [MAG_W-1:0]  threshold_r;
  logic [CNT_W-1:0]  win_len_r;
  logic [CNT_W-1:0]  hysteresis_r;
  logic [CHAN_W-1:0] channels_r;

  logic signed [SAMPLE_W-1:0] samples  [MAX_CHANNELS];
  logic        [MAG_W-1:0]    lane_mag [MAX_CHANNELS];

  ste_cfg_t   cfg;
  logic       frm_valid;
  logic       frm_ready;
  ste_frame_t frm;
  logic       res_valid;
  logic       res_ready;
  ste_res_t   res;

  logic             out_valid_r;
  logic             out_found_r;
  logic [POS_W-1:0] out_begin_r;
  logic [POS_W-1:0] out_end_r;
  logic [POS_W-1:0] last_clamp;
  logic [POS_W-1:0] end_val;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= MAG_W'(8389);
      win_len_r    <= CNT_W'(480);
      hysteresis_r <= CNT_W'(1);
      channels_r   <= CHAN_W'(2);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_THRESHOLD:  threshold_r  <= cfg_ch.data[MAG_W-1:0];
        REG_WINDOW:     win_len_r    <= cfg_ch.data[CNT_W-1:0];
        REG_HYSTERESIS: hysteresis_r <= cfg_ch.data[CNT_W-1:0];
        REG_CHANNELS:   channels_r   <= cfg_ch.data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.threshold = threshold_r;
  assign cfg.win_len   = win_len_r;
  assign cfg.hyst_len  = hysteresis_r;

  // sample lanes
  assign samples[0] = in_ch.sample_0;
  assign samples[1] = in_ch.sample_1;
  assign samples[2] = in_ch.sample_2;
  assign samples[3] = in_ch.sample_3;

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    ste_lane u_lane (
      .sample (samples[c]),
      .en     (CHAN_W'(c) < channels_r),
      .mag    (lane_mag[c])
    );
  end

  ste_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .lane_mag  (lane_mag),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_func   (in_ch.func),
    .in_total  (in_ch.track_len),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm       (frm)
  );

  ste_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm       (frm),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // end point clamped to track length, never below the start
  assign last_clamp = (res.last < res.total) ? res.last : res.total;
  assign end_val    = (last_clamp > res.first) ? last_clamp : res.first;
  assign res_ready  = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_found_r <= res.found;
      out_begin_r <= res.found ? res.first : '0;
      out_end_r   <= res.found ? end_val : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.sound_found = out_found_r;
  assign out_ch.begin_frame = out_begin_r;
  assign out_ch.end_frame   = out_end_r;

endmodule
